### design/line_regex_matcher_defines.svh
// Assertion macros shared by the line regex matcher checker.
`ifndef LINE_REGEX_MATCHER_DEFINES_SVH
`define LINE_REGEX_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define LRM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_regex_matcher port check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define LRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_regex_matcher port check failed");

`endif

### design/lrm_pkg.sv
// Shared types, constants and helper functions of the line regex matcher.
package lrm_pkg;

  localparam int unsigned REG_W         = 64;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CNT_W         = 24;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned PAT_REG_WORDS = 4;
  localparam int unsigned PAT_REG_BYTES = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [REG_W-1:0] PATTERN_WORD_0_RESET = 64'd46;
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 6'd1;
  localparam logic [CNT_W-1:0] CNT_MAX              = 24'hFFFFFF;

  // Per-beat controls broadcast to every position cell.
  typedef struct packed {
    logic       step;       // a text beat is accepted this cycle
    logic       consume;    // the byte advances the automaton
    logic       restart;    // the line ends, reload the start closure
    logic [7:0] text_fold;  // text byte with letters folded to lower case
  } lrm_ctrl_t;

  // Skip links of the three closure chains, handed two cells onward.
  typedef struct packed {
    logic cur;   // closure of the live set held in the cells
    logic nxt;   // closure of the set after consuming the byte
    logic rst;   // closure of the start position for a new line
  } lrm_skip_t;

  // One finished-line result.
  typedef struct packed {
    logic             line_hit;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] match_total;
    logic             final_line;
  } lrm_result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### design/lrm_cell.sv
// One pattern position of the NFA: its live bit, token compare and closure links.
module lrm_cell #(
  parameter logic RST_ACTIVE = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrm_pkg::lrm_ctrl_t ctrl_i,
  input  logic [7:0]         pat_byte_i,
  input  logic               below_n_i,
  input  logic               valid_prev_i,
  output logic               valid_o,
  input  logic               star_next_i,
  output logic               star_tok_o,
  input  logic               seed_i,
  input  logic               rseed_i,
  input  lrm_pkg::lrm_skip_t skip_i,
  output lrm_pkg::lrm_skip_t skip_o,
  input  logic               cons_i,
  output logic               cons_o,
  output logic               cur_end_o,
  output logic               nxt_end_o
);

  logic act_q, act_d;
  logic keep, cur, nxt, rst_set, tok_ok, take;

  // A position exists up to and including the pattern length.
  assign keep       = valid_prev_i;
  assign valid_o    = valid_prev_i & below_n_i & (pat_byte_i != 8'h00);
  assign star_tok_o = valid_o & (pat_byte_i == lrm_pkg::CH_STAR);

  assign cur    = keep & (act_q | skip_i.cur);
  assign tok_ok = valid_o & ((pat_byte_i == lrm_pkg::CH_DOT) |
                  (lrm_pkg::fold_case(pat_byte_i) == ctrl_i.text_fold));
  assign take   = cur & tok_ok;

  // A starred token loops on itself, a plain one hands off to the right.
  assign cons_o  = take & ~star_next_i;
  assign nxt     = keep & (seed_i | cons_i | (take & star_next_i) | skip_i.nxt);
  assign rst_set = keep & (rseed_i | skip_i.rst);

  assign skip_o.cur = cur & star_next_i;
  assign skip_o.nxt = nxt & star_next_i;
  assign skip_o.rst = rst_set & star_next_i;

  // The end position is the only kept position that holds no token.
  assign cur_end_o = cur & ~valid_o;
  assign nxt_end_o = nxt & ~valid_o;

  always_comb begin
    act_d = act_q;
    if (ctrl_i.step) begin
      if (ctrl_i.restart) begin
        act_d = rst_set;
      end else if (ctrl_i.consume) begin
        act_d = nxt;
      end else begin
        act_d = cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= RST_ACTIVE;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

### design/line_regex_matcher.sv
// Top level of the line regex matcher: configuration, cell row, counters, output stage.
// Output: the result of the beat that ends a line is registered in the output register, or in
// the skid entry while the port stalls. Throughput: one text beat per cycle unless in_stall_o
// is high; the NFA update of a byte is combinational, rippling through PATTERN_MAX+1 cells.
// Reset (rst_ni low, asynchronous): pattern ".", length 1, line number 1, match count 0,
// empty output stage; no clearing pass is needed.
module line_regex_matcher #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LINE_LIMIT  = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [lrm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lrm_pkg::REG_W-1:0]        cfg_data_i,
  // Text channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       text_byte_i,
  input  logic                             end_of_text_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             line_hit_o,
  output logic [lrm_pkg::CNT_W-1:0]        line_number_o,
  output logic [lrm_pkg::CNT_W-1:0]        match_total_o,
  output logic                             final_line_o
);

  localparam int unsigned NPOS   = PATTERN_MAX + 1;
  localparam int unsigned KEPT_W = $clog2(LINE_LIMIT);

  // Configuration registers. The pattern bytes are kept as one flat vector,
  // byte i at bits 8i, so each cell can pick its own byte at a fixed place.
  logic [lrm_pkg::PAT_REG_WORDS*lrm_pkg::REG_W-1:0] pat_regs_q;
  logic [lrm_pkg::LEN_W-1:0]                        pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_regs_q <= {{(lrm_pkg::PAT_REG_WORDS-1)*lrm_pkg::REG_W{1'b0}},
                     lrm_pkg::PATTERN_WORD_0_RESET};
      pat_len_q  <= lrm_pkg::PATTERN_LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lrm_pkg::CFG_PATTERN_WORD_0: begin
          pat_regs_q[0*lrm_pkg::REG_W +: lrm_pkg::REG_W] <= cfg_data_i;
        end
        lrm_pkg::CFG_PATTERN_WORD_1: begin
          pat_regs_q[1*lrm_pkg::REG_W +: lrm_pkg::REG_W] <= cfg_data_i;
        end
        lrm_pkg::CFG_PATTERN_WORD_2: begin
          pat_regs_q[2*lrm_pkg::REG_W +: lrm_pkg::REG_W] <= cfg_data_i;
        end
        lrm_pkg::CFG_PATTERN_WORD_3: begin
          pat_regs_q[3*lrm_pkg::REG_W +: lrm_pkg::REG_W] <= cfg_data_i;
        end
        lrm_pkg::CFG_PATTERN_LENGTH: begin
          pat_len_q <= cfg_data_i[lrm_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Beat handshake and per-beat decisions. A byte is examined only while the
  // line is still within its first LINE_LIMIT-1 bytes; a newline never is.
  logic               accept, is_nl, line_end, below_limit;
  logic               pat_start;
  logic [KEPT_W-1:0]  kept_q, kept_d;
  lrm_pkg::lrm_ctrl_t ctrl;

  assign accept      = in_valid_i & ~in_stall_o;
  assign is_nl       = (text_byte_i == lrm_pkg::CH_NEWLINE);
  assign below_limit = (kept_q < KEPT_W'(LINE_LIMIT - 1));
  assign line_end    = is_nl | end_of_text_i;

  assign ctrl.step      = accept;
  assign ctrl.consume   = accept & ~is_nl & below_limit;
  assign ctrl.restart   = accept & line_end;
  assign ctrl.text_fold = lrm_pkg::fold_case(text_byte_i);

  // The row of position cells. Each cell talks to its right neighbor (the
  // consumed token hands its bit onward, the star flag comes back) and to
  // the cell two places on (the skip over a starred token). Cell PATTERN_MAX
  // only ever serves as the end position of a full-length pattern.
  logic               valid     [NPOS];
  logic               star_tok  [NPOS];
  logic               cons      [NPOS];
  lrm_pkg::lrm_skip_t skip      [NPOS];
  logic [NPOS-1:0]    cur_end;
  logic [NPOS-1:0]    nxt_end;

  // A leading caret anchors: the line starts at position one and position
  // zero is not re-seeded after every byte.
  assign pat_start = valid[0] &
                     (pat_regs_q[7:0] == lrm_pkg::CH_CARET);

  for (genvar p = 0; p < NPOS; p++) begin : g_cell
    logic [7:0]         pat_byte;
    logic               below_n;
    logic               valid_prev;
    logic               star_next;
    logic               seed;
    logic               rseed;
    logic               cons_in;
    lrm_pkg::lrm_skip_t skip_in;

    if (p < lrm_pkg::PAT_REG_BYTES) begin : g_reg_byte
      assign pat_byte = pat_regs_q[8*p +: 8];
    end else begin : g_zero_byte
      assign pat_byte = 8'h00;
    end

    assign below_n = (p < PATTERN_MAX) &&
                     ({1'b0, pat_len_q} > (lrm_pkg::LEN_W+1)'(p));

    if (p == 0) begin : g_head
      assign valid_prev = 1'b1;
      assign cons_in    = 1'b0;
      assign seed       = ~pat_start;
      assign rseed      = ~pat_start;
    end else begin : g_body
      assign valid_prev = valid[p-1];
      assign cons_in    = cons[p-1];
      assign seed       = 1'b0;
      assign rseed      = (p == 1) ? pat_start : 1'b0;
    end

    if (p < 2) begin : g_no_skip
      assign skip_in = '0;
    end else begin : g_skip
      assign skip_in = skip[p-2];
    end

    if (p == NPOS - 1) begin : g_tail
      assign star_next = 1'b0;
    end else begin : g_star
      assign star_next = star_tok[p+1];
    end

    lrm_cell #(
      .RST_ACTIVE ((p == 0) ? 1'b1 : 1'b0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pat_byte_i   (pat_byte),
      .below_n_i    (below_n),
      .valid_prev_i (valid_prev),
      .valid_o      (valid[p]),
      .star_next_i  (star_next),
      .star_tok_o   (star_tok[p]),
      .seed_i       (seed),
      .rseed_i      (rseed),
      .skip_i       (skip_in),
      .skip_o       (skip[p]),
      .cons_i       (cons_in),
      .cons_o       (cons[p]),
      .cur_end_o    (cur_end[p]),
      .nxt_end_o    (nxt_end[p])
    );
  end

  // Line state: the line has matched once the end position was live, either
  // before this byte or after consuming it.
  logic                      matched_q, matched_d;
  logic                      hit_now;
  logic [lrm_pkg::CNT_W-1:0] line_cnt_q, line_cnt_d;
  logic [lrm_pkg::CNT_W-1:0] match_cnt_q, match_cnt_d;
  logic [lrm_pkg::CNT_W-1:0] total;
  lrm_pkg::lrm_result_t      result;

  assign hit_now = matched_q | (|cur_end) | (ctrl.consume & (|nxt_end));
  assign total   = (hit_now && match_cnt_q != lrm_pkg::CNT_MAX) ?
                   match_cnt_q + lrm_pkg::CNT_W'(1) : match_cnt_q;

  assign result.line_hit    = hit_now;
  assign result.line_number = line_cnt_q;
  assign result.match_total = total;
  assign result.final_line  = end_of_text_i;

  always_comb begin
    matched_d   = matched_q;
    kept_d      = kept_q;
    line_cnt_d  = line_cnt_q;
    match_cnt_d = match_cnt_q;
    if (accept) begin
      matched_d = hit_now;
      if (ctrl.consume) begin
        kept_d = kept_q + KEPT_W'(1);
      end
      if (line_end) begin
        matched_d   = 1'b0;
        kept_d      = '0;
        match_cnt_d = total;
        if (line_cnt_q != lrm_pkg::CNT_MAX) begin
          line_cnt_d = line_cnt_q + lrm_pkg::CNT_W'(1);
        end
        // The last byte of a text closes it: the next beat opens a new text.
        if (end_of_text_i) begin
          line_cnt_d  = lrm_pkg::CNT_W'(1);
          match_cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q   <= 1'b0;
      kept_q      <= '0;
      line_cnt_q  <= lrm_pkg::CNT_W'(1);
      match_cnt_q <= '0;
    end else begin
      matched_q   <= matched_d;
      kept_q      <= kept_d;
      line_cnt_q  <= line_cnt_d;
      match_cnt_q <= match_cnt_d;
    end
  end

  // Output stage: a result register plus one skid entry. A new text beat is
  // taken while a result waits on the port; the input stalls only when the
  // skid entry is also full, since that beat might end another line.
  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  lrm_pkg::lrm_result_t out_q, skid_q;
  logic                 out_pop, res_fire, load_out, load_skid, move_skid;

  assign out_pop  = out_valid_q & ~out_stall_i;
  assign res_fire = ctrl.restart;

  always_comb begin
    out_valid_d  = out_valid_q & ~out_pop;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    move_skid    = 1'b0;
    if (skid_valid_q && out_pop) begin
      move_skid    = 1'b1;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end
    if (res_fire) begin
      if (!out_valid_q || out_pop) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= result;
    end
    if (load_skid) begin
      skid_q <= result;
    end
  end

  assign in_stall_o    = skid_valid_q;
  assign out_valid_o   = out_valid_q;
  assign line_hit_o    = out_q.line_hit;
  assign line_number_o = out_q.line_number;
  assign match_total_o = out_q.match_total;
  assign final_line_o  = out_q.final_line;

endmodule

### design/lrm_checker.sv
// Port-level checker of the line regex matcher and its bind to the top level.
`include "line_regex_matcher_defines.svh"

module lrm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      line_hit_o,
  input logic [lrm_pkg::CNT_W-1:0] line_number_o,
  input logic [lrm_pkg::CNT_W-1:0] match_total_o,
  input logic                      final_line_o
);

  logic [2*lrm_pkg::CNT_W+1:0] out_beat;
  logic                        first_line;
  logic [lrm_pkg::CNT_W-1:0]   hit_only;

  assign out_beat   = {line_hit_o, line_number_o, match_total_o, final_line_o};
  assign first_line = (line_number_o == lrm_pkg::CNT_W'(1));
  assign hit_only   = lrm_pkg::CNT_W'(line_hit_o);

  // A stalled result beat holds its payload.
  `LRM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat))

  // Matching lines never outnumber lines.
  `LRM_ASSERT_SAME(a_total_le_line, out_valid_o, match_total_o <= line_number_o)

  // A hit is counted in its own beat.
  `LRM_ASSERT_SAME(a_hit_counted, out_valid_o && line_hit_o, match_total_o != '0)

  // On the first line of a text the total is that line's hit alone.
  `LRM_ASSERT_SAME(a_first_line, out_valid_o && first_line, match_total_o == hit_only)

  // The input stalls only behind a waiting result.
  `LRM_ASSERT_SAME(a_stall_behind_beat, in_stall_o, out_valid_o)

endmodule

bind line_regex_matcher lrm_checker u_lrm_checker (.*);
